>>> rtl/spmc_pkg.sv
`timescale 1ns / 1ps

package spmc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int AVG_BITS    = SAMPLE_BITS + 4;
  localparam int MIN_BITS    = SAMPLE_BITS + 1;
  localparam int CFG_IDX_BITS = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_LOUD  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUIET = 1'd1;

  // Light mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_QUIET = 2'd1;
  localparam logic [1:0] MODE_SOUND = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] LOUD_RESET  = SAMPLE_BITS'(621);
  localparam logic [AVG_BITS-1:0]    QUIET_RESET = AVG_BITS'(993);
  localparam logic [MIN_BITS-1:0]    MIN_RESET   = MIN_BITS'(1) << SAMPLE_BITS;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_to_peak;
    logic [AVG_BITS-1:0]    average_level;
    logic [1:0]             light_mode;
    logic                   toggled;
  } result_t;

endpackage

>>> rtl/sound_peak_mode_controller.sv
`timescale 1ns / 1ps

// Peak-to-peak sound level detector with a three-state light mode.
// Input channel (in_valid/in_ready): one microphone sample per request plus
// a window-end mark. Samples without the mark only update the window max/min
// and produce no result. A marked sample closes the window: the block forms
// max - min, updates the running average (u10.4) and the light mode, and
// emits one result request on the out_ channel.
// Path: a request accepted into the stage register is evaluated there and
// its result is written into the result buffer, which drives out_valid.
// Throughput: one request per cycle unless stalled as below; the evaluate
// stage is compare, subtract and halve logic before the result buffer.
// A two-entry result buffer decouples the channels, so samples keep flowing
// while a result waits; only a window-end sample stalls, when both entries
// are still held by a stalled receiver.
// Configuration (cfg_we/cfg_index/cfg_wdata): write while idle. Index 0 is
// the loud threshold, index 1 the quiet threshold.
// Reset (synchronous, rst_n low): thresholds to 621 and 993, window cleared,
// average zero, mode quiet pattern, result buffer empty.
module sound_peak_mode_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spmc_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic                              in_window_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spmc_pkg::SAMPLE_BITS-1:0]  out_peak_to_peak,
  output logic [spmc_pkg::AVG_BITS-1:0]     out_average_level,
  output logic [1:0]                        out_light_mode,
  output logic                              out_toggled,
  input  logic                              cfg_we,
  input  logic [spmc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [spmc_pkg::AVG_BITS-1:0]     cfg_wdata
);
  import spmc_pkg::*;

  logic [SAMPLE_BITS-1:0] loud_r, loud_nxt;
  logic [AVG_BITS-1:0]    quiet_r, quiet_nxt;

  // stage register in front of the evaluate logic
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_we_r;
  logic                   s1_go;
  logic                   in_take;

  logic    buf_full;
  logic    res_push;
  result_t res;
  result_t out_data;

  always_comb begin
    loud_nxt  = loud_r;
    quiet_nxt = quiet_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LOUD:  loud_nxt  = cfg_wdata[SAMPLE_BITS-1:0];
        REG_QUIET: quiet_nxt = cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    // a window-end request needs a free result entry; others always advance
    s1_go        = s1_valid_r && (!s1_we_r || !buf_full);
    in_ready     = !s1_valid_r || s1_go;
    in_take      = in_valid && in_ready;
    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_r     <= LOUD_RESET;
      quiet_r    <= QUIET_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      loud_r     <= loud_nxt;
      quiet_r    <= quiet_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_we_r     <= in_window_end;
    end
  end

  spmc_eval u_eval (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_go),
    .sample          (s1_sample_r),
    .window_end      (s1_we_r),
    .loud_threshold  (loud_r),
    .quiet_threshold (quiet_r),
    .res_push        (res_push),
    .res             (res)
  );

  spmc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_peak_to_peak  = out_data.peak_to_peak;
  assign out_average_level = out_data.average_level;
  assign out_light_mode    = out_data.light_mode;
  assign out_toggled       = out_data.toggled;

endmodule

>>> rtl/spmc_eval.sv
`timescale 1ns / 1ps

module spmc_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [spmc_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            window_end,
  input  logic [spmc_pkg::SAMPLE_BITS-1:0] loud_threshold,
  input  logic [spmc_pkg::AVG_BITS-1:0]    quiet_threshold,
  output logic                            res_push,
  output spmc_pkg::result_t               res
);
  import spmc_pkg::*;

  logic [SAMPLE_BITS-1:0] max_r, max_nxt, max_upd;
  logic [MIN_BITS-1:0]    min_r, min_nxt, min_upd;
  logic [AVG_BITS-1:0]    avg_r, avg_nxt, avg_upd;
  logic [1:0]             mode_r, mode_nxt, mode_upd;
  logic [SAMPLE_BITS-1:0] p2p;
  logic [AVG_BITS:0]      avg_sum;
  logic                   loud;

  always_comb begin
    max_upd = max_r;
    min_upd = min_r;
    // a new maximum skips the minimum test
    if (sample > max_r) begin
      max_upd = sample;
    end else if (MIN_BITS'(sample) < min_r) begin
      min_upd = MIN_BITS'(sample);
    end

    // min still at its reset value when never set: saturate to zero
    if (MIN_BITS'(max_upd) >= min_upd) begin
      p2p = max_upd - min_upd[SAMPLE_BITS-1:0];
    end else begin
      p2p = '0;
    end

    avg_sum = (AVG_BITS+1)'(avg_r) + (AVG_BITS+1)'({p2p, 4'b0000});
    avg_upd = avg_sum[AVG_BITS:1];

    loud = (p2p >= loud_threshold);
    if (loud) begin
      mode_upd = (mode_r == MODE_OFF) ? MODE_QUIET : MODE_OFF;
    end else if (mode_r != MODE_OFF) begin
      mode_upd = (avg_upd < quiet_threshold) ? MODE_QUIET : MODE_SOUND;
    end else begin
      mode_upd = MODE_OFF;
    end

    max_nxt  = max_r;
    min_nxt  = min_r;
    avg_nxt  = avg_r;
    mode_nxt = mode_r;
    if (step) begin
      if (window_end) begin
        max_nxt  = '0;
        min_nxt  = MIN_RESET;
        avg_nxt  = avg_upd;
        mode_nxt = mode_upd;
      end else begin
        max_nxt = max_upd;
        min_nxt = min_upd;
      end
    end

    res_push          = step && window_end;
    res.peak_to_peak  = p2p;
    res.average_level = avg_upd;
    res.light_mode    = mode_upd;
    res.toggled       = loud;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= '0;
      min_r  <= MIN_RESET;
      avg_r  <= '0;
      mode_r <= MODE_QUIET;
    end else begin
      max_r  <= max_nxt;
      min_r  <= min_nxt;
      avg_r  <= avg_nxt;
      mode_r <= mode_nxt;
    end
  end

  a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (max_r == '0) && (min_r == MIN_RESET))
    else $error("window trackers not cleared after window end");

  a_toggle_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.toggled) |=> (mode_r == MODE_OFF) == ($past(mode_r) != MODE_OFF))
    else $error("loud window did not toggle the mode");

  a_hold_mid_window: assert property (@(posedge clk) disable iff (!rst_n)
    !res_push |=> $stable(avg_r) && $stable(mode_r))
    else $error("average or mode changed without a window end");

endmodule

>>> rtl/spmc_obuf.sv
`timescale 1ns / 1ps

module spmc_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spmc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output spmc_pkg::result_t out_data
);
  import spmc_pkg::*;

  result_t    mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  always_comb begin
    full      = (count_r == 2'd2);
    out_valid = (count_r != 2'd0);
    pop       = out_valid && out_ready;
    out_data  = mem_r[rptr_r];
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
